// File: rtl/core/rgbps_pkg.sv
// ----------------------------------------------------------------------------
// RGB PWM and digit scan package
// Shared types, register indexes and seven-segment lookup functions.
// ----------------------------------------------------------------------------
package rgbps_pkg;

  localparam int unsigned NumChannels = 3;
  localparam int unsigned LevelWidth  = 7;
  localparam int unsigned SegWidth    = 7;
  localparam int unsigned DigitCount  = 3;

  typedef logic [LevelWidth-1:0] level_t;
  typedef level_t [NumChannels-1:0] levels_t;
  typedef logic [SegWidth-1:0] seg_t;
  typedef logic [1:0] reg_idx_t;

  // Configuration register indexes, which double as channel numbers.
  localparam reg_idx_t RegRed   = 2'd0;
  localparam reg_idx_t RegGreen = 2'd1;
  localparam reg_idx_t RegBlue  = 2'd2;

  // What the scan unit hands to the top level: the lit digit and its pattern.
  typedef struct packed {
    logic [DigitCount-1:0] enables;
    seg_t                  segments;
  } disp_t;

  // Decimal digit to segment pattern; anything above nine is blank.
  function automatic seg_t digit_pattern(input logic [3:0] d);
    seg_t p;
    case (d)
      4'd0:    p = 7'h3F;
      4'd1:    p = 7'h06;
      4'd2:    p = 7'h5B;
      4'd3:    p = 7'h4F;
      4'd4:    p = 7'h66;
      4'd5:    p = 7'h6D;
      4'd6:    p = 7'h7D;
      4'd7:    p = 7'h07;
      4'd8:    p = 7'h7F;
      4'd9:    p = 7'h67;
      default: p = '0;
    endcase
    return p;
  endfunction

  // Letter r, g or b naming a channel.
  function automatic seg_t letter_pattern(input reg_idx_t ch);
    seg_t p;
    case (ch)
      RegRed:   p = 7'h50;
      RegGreen: p = 7'h6F;
      RegBlue:  p = 7'h7C;
      default:  p = '0;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/core/rgbps_pwm.sv
// ----------------------------------------------------------------------------
// RGB PWM generator
// Cyclic duty counter and the three registered LED drive bits.
// ----------------------------------------------------------------------------
module rgbps_pwm #(
  parameter int unsigned PWM_PERIOD = 100
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  step_i,
  input  rgbps_pkg::levels_t                    levels_i,
  output logic [rgbps_pkg::NumChannels-1:0]     leds_o
);

  localparam int unsigned CntW = $clog2(PWM_PERIOD + 1);
  localparam int unsigned CmpW = (CntW > rgbps_pkg::LevelWidth) ? CntW : rgbps_pkg::LevelWidth;

  logic [CntW-1:0]                      count_q, count_d;
  logic [rgbps_pkg::NumChannels-1:0]    leds_q, leds_d;

  // An LED is on while the count sits in 1 up to one below its level.
  always_comb begin
    for (int i = 0; i < rgbps_pkg::NumChannels; i++) begin
      leds_d[i] = (count_q != '0) && (CmpW'(count_q) < CmpW'(levels_i[i]));
    end
    count_d = (count_q >= CntW'(PWM_PERIOD)) ? CntW'(1) : count_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      leds_q  <= '0;
    end else if (step_i) begin
      count_q <= count_d;
      leds_q  <= leds_d;
    end
  end

  assign leds_o = leds_q;

endmodule

// File: rtl/core/rgbps_scan.sv
// ----------------------------------------------------------------------------
// Digit scan unit
// Steps the lit digit, holds the pattern store and reloads it per channel.
// ----------------------------------------------------------------------------
module rgbps_scan #(
  parameter int unsigned CHANNEL_HOLD_TICKS = 300
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  rgbps_pkg::levels_t  levels_i,
  output rgbps_pkg::disp_t    disp_o
);

  localparam int unsigned ScanW = $clog2(3 * CHANNEL_HOLD_TICKS + 1);
  localparam int unsigned Hold1 = CHANNEL_HOLD_TICKS;
  localparam int unsigned Hold2 = 2 * CHANNEL_HOLD_TICKS;
  localparam int unsigned Hold3 = 3 * CHANNEL_HOLD_TICKS;

  logic [1:0]               digit_q, digit_d, digit_sel;
  logic [ScanW-1:0]         scan_q, scan_d, scan_inc;
  rgbps_pkg::seg_t          store_q [rgbps_pkg::DigitCount];
  rgbps_pkg::disp_t         disp_q, disp_d;
  logic                     load;
  rgbps_pkg::reg_idx_t      load_ch;
  rgbps_pkg::level_t        load_lvl;
  logic [14:0]              tens_prod;
  logic [3:0]               tens;
  rgbps_pkg::level_t        units;

  always_comb begin
    digit_sel = (digit_q > 2'd2) ? 2'd0 : digit_q;
    digit_d   = (digit_sel == 2'd2) ? 2'd0 : digit_sel + 2'd1;

    disp_d.enables  = ~(3'b001 << digit_sel);
    disp_d.segments = store_q[digit_sel];

    scan_inc = scan_q + ScanW'(1);
    load     = 1'b1;
    load_ch  = rgbps_pkg::RegRed;
    scan_d   = scan_inc;
    if (scan_inc == ScanW'(Hold1)) begin
      load_ch = rgbps_pkg::RegRed;
    end else if (scan_inc == ScanW'(Hold2)) begin
      load_ch = rgbps_pkg::RegGreen;
    end else if (scan_inc >= ScanW'(Hold3)) begin
      load_ch = rgbps_pkg::RegBlue;
      scan_d  = '0;
    end else begin
      load = 1'b0;
    end

    // Split the level into tens and units: x*205 >> 11 is x/10 for x below 128.
    load_lvl  = levels_i[load_ch];
    tens_prod = 15'(load_lvl) * 15'd205;
    tens      = tens_prod[14:11];
    units     = load_lvl - rgbps_pkg::level_t'(tens) * rgbps_pkg::level_t'(10);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q          <= '0;
      scan_q           <= '0;
      disp_q.enables   <= '1;
      disp_q.segments  <= '0;
      for (int i = 0; i < rgbps_pkg::DigitCount; i++) begin
        store_q[i] <= '0;
      end
    end else if (step_i) begin
      digit_q <= digit_d;
      scan_q  <= scan_d;
      disp_q  <= disp_d;
      if (load) begin
        store_q[0] <= rgbps_pkg::letter_pattern(load_ch);
        store_q[1] <= rgbps_pkg::digit_pattern(tens);
        store_q[2] <= rgbps_pkg::digit_pattern(units[3:0]);
      end
    end
  end

  assign disp_o = disp_q;

endmodule

// File: rtl/core/rgb_pwm_with_digit_scan.sv
// ----------------------------------------------------------------------------
// RGB PWM with digit scan
// Three-channel LED PWM and a three-digit multiplexed seven-segment display.
// ----------------------------------------------------------------------------
// Each input beat carries a PWM tick, a scan tick, both or neither, and yields
// exactly one output beat showing the LED drives and the display drive after
// that beat's ticks are applied. A beat is first captured in an input register
// and, once the result slot is free, updates the PWM counter and the scan
// state, whose registers are themselves the output register. One beat is
// accepted every cycle while the output side keeps taking results.
// When the output stalls the input register holds its beat and the input
// stalls in turn. The PWM counter runs 1..PWM_PERIOD and an LED is on while
// the count is at least one and below its level, so level zero keeps it dark.
// Every CHANNEL_HOLD_TICKS scan ticks the digits reload with r, g or b and the
// tens and units digits of the next channel's level (a tens digit above nine
// is blank); the display is blank until the first reload. The user must write
// levels through the plain write port only while no beat is in flight; the
// block does not enforce it. An index past the blue register is ignored.
module rgb_pwm_with_digit_scan #(
  parameter int unsigned PWM_PERIOD         = 100,
  parameter int unsigned CHANNEL_HOLD_TICKS = 300
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        pwm_tick_i,
  input  logic                        scan_tick_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        led_red_o,
  output logic                        led_green_o,
  output logic                        led_blue_o,
  output logic [2:0]                  digit_enables_o,
  output logic [6:0]                  segments_o,
  input  logic                        cfg_we_i,
  input  rgbps_pkg::reg_idx_t         cfg_idx_i,
  input  logic [6:0]                  cfg_wdata_i
);

  logic                               in_valid_q;
  logic                               pwm_tick_q, scan_tick_q;
  logic                               out_valid_q;
  logic                               out_free;
  logic                               advance;
  rgbps_pkg::levels_t                 levels_q;
  logic [rgbps_pkg::NumChannels-1:0]  leds;
  rgbps_pkg::disp_t                   disp;

  // The result slot is free when empty or being taken this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Input payload register; it holds while the beat waits for the result slot.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      pwm_tick_q  <= pwm_tick_i;
      scan_tick_q <= scan_tick_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rgbps_pkg::RegRed:   levels_q[rgbps_pkg::RegRed]   <= cfg_wdata_i;
        rgbps_pkg::RegGreen: levels_q[rgbps_pkg::RegGreen] <= cfg_wdata_i;
        rgbps_pkg::RegBlue:  levels_q[rgbps_pkg::RegBlue]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rgbps_pwm #(
    .PWM_PERIOD (PWM_PERIOD)
  ) u_pwm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance && pwm_tick_q),
    .levels_i (levels_q),
    .leds_o   (leds)
  );

  rgbps_scan #(
    .CHANNEL_HOLD_TICKS (CHANNEL_HOLD_TICKS)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance && scan_tick_q),
    .levels_i (levels_q),
    .disp_o   (disp)
  );

  assign out_valid_o     = out_valid_q;
  assign led_red_o       = leds[rgbps_pkg::RegRed];
  assign led_green_o     = leds[rgbps_pkg::RegGreen];
  assign led_blue_o      = leds[rgbps_pkg::RegBlue];
  assign digit_enables_o = disp.enables;
  assign segments_o      = disp.segments;

`ifndef SYNTHESIS
  // At most one digit is ever driven.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(digit_enables_o) >= 2)
    else $error("more than one digit enabled");

  // The input only stalls while a beat sits in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  // Outputs change only when a buffered beat moves into the result slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable({leds, disp}))
    else $error("outputs changed without a beat");

  // A beat reaching the result slot always produces a valid result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed beat lost");
`endif

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the RGB PWM with digit scan block
// Drives tick beats under random idling and back-pressure and checks every
// result beat against a cycle-free prediction of LEDs and display.
// ----------------------------------------------------------------------------
// An initial block programs the three duty levels and fills a queue of pending
// tick beats, one phase per level setting. A driver at the falling edge offers
// those beats and a receiver at the falling edge raises the output stall in
// random bursts. A monitor at the rising edge predicts the result of each
// accepted input beat and compares each accepted output beat, field by field,
// against the oldest prediction. The level registers are written only once
// the block has drained.
module testbench;

  localparam int unsigned PwmPeriod  = 100;
  localparam int unsigned HoldTicks  = 300;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumPhases  = 7;
  localparam int unsigned PhaseBeats = 165;
  // Long receiver hold-off used once to fill the block and stall its input.
  localparam int unsigned LongHold   = 80;

  // The one index the port can carry that names no register.
  localparam rgbps_pkg::reg_idx_t RegSpare = 2'd3;

  // Seven-segment glyphs, segment a in bit 0. Digit d sits at element d.
  localparam logic [9:0][6:0] DigitGlyph = {
    7'h67, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };
  // Letters r, g and b, indexed by channel.
  localparam logic [2:0][6:0] LetterGlyph = {7'h7C, 7'h6F, 7'h50};

  typedef struct packed {
    logic            red;
    logic            green;
    logic            blue;
    logic [2:0]      enables;
    rgbps_pkg::seg_t segments;
  } panel_t;

  typedef struct packed {
    logic pwm;
    logic scan;
  } ticks_t;

  // DUT connections; every input starts at a known value.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic                pwm_tick_i  = 1'b0;
  logic                scan_tick_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                led_red_o;
  logic                led_green_o;
  logic                led_blue_o;
  logic [2:0]          digit_enables_o;
  logic [6:0]          segments_o;
  logic                cfg_we_i    = 1'b0;
  rgbps_pkg::reg_idx_t cfg_idx_i   = rgbps_pkg::RegRed;
  logic [6:0]          cfg_wdata_i = '0;

  // Stimulus and expectations.
  ticks_t      tick_q[$];
  panel_t      panel_due_q[$];
  ticks_t      next_beat;
  logic        in_taken = 1'b0;

  // Idling control, set by the sequencing block between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        quiet         = 1'b0;
  int unsigned send_gap      = 0;
  int unsigned recv_hold     = 0;
  logic        long_hold_done = 1'b0;

  // Predicted block state.
  rgbps_pkg::level_t duty [rgbps_pkg::NumChannels];
  int unsigned       pwm_phase   = 0;
  logic [2:0]        lamp_bits   = '0;
  int unsigned       digit_sel   = 0;
  int unsigned       hold_count  = 0;
  rgbps_pkg::seg_t   glyph [rgbps_pkg::DigitCount];
  logic [2:0]        lit_enables = 3'b111;
  rgbps_pkg::seg_t   lit_segments = '0;

  // Bookkeeping.
  int unsigned mismatches     = 0;
  int unsigned results_seen   = 0;
  int unsigned pwm_ticks      = 0;
  int unsigned scan_ticks     = 0;
  int unsigned reloads        = 0;
  int unsigned input_stalled  = 0;
  int unsigned cycle_cnt      = 0;

  rgb_pwm_with_digit_scan #(
    .PWM_PERIOD        (PwmPeriod),
    .CHANNEL_HOLD_TICKS(HoldTicks)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pwm_tick_i     (pwm_tick_i),
    .scan_tick_i    (scan_tick_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .led_red_o      (led_red_o),
    .led_green_o    (led_green_o),
    .led_blue_o     (led_blue_o),
    .digit_enables_o(digit_enables_o),
    .segments_o     (segments_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Fill the display store with the letter and the two decimal digits of one
  // channel's level. A tens digit above nine has no glyph and shows blank.
  task automatic load_glyphs(input rgbps_pkg::reg_idx_t ch);
    int unsigned v;
    v = duty[ch];
    glyph[0] = LetterGlyph[ch];
    glyph[1] = (v / 10 < 10) ? DigitGlyph[v / 10] : '0;
    glyph[2] = DigitGlyph[v % 10];
    reloads++;
  endtask

  // Apply one accepted beat to the predicted state and queue the result that
  // the block must return for it.
  task automatic step_panel(input logic pwm, input logic scan);
    int unsigned d;
    panel_t p;
    if (pwm) begin
      pwm_ticks++;
      // The LED decision uses the count before it advances, so the very
      // first tick after reset sees zero and leaves every LED dark.
      for (int ch = 0; ch < rgbps_pkg::NumChannels; ch++) begin
        lamp_bits[ch] = (pwm_phase >= 1) && (pwm_phase < duty[ch]);
      end
      pwm_phase = (pwm_phase >= PwmPeriod) ? 1 : pwm_phase + 1;
    end
    if (scan) begin
      scan_ticks++;
      d = digit_sel;
      lit_enables  = ~(3'b001 << d);
      lit_segments = glyph[d];
      digit_sel    = (d >= 2) ? 0 : d + 1;
      // The reload only shows from the next scan tick on.
      hold_count++;
      if (hold_count == HoldTicks) begin
        load_glyphs(rgbps_pkg::RegRed);
      end else if (hold_count == 2 * HoldTicks) begin
        load_glyphs(rgbps_pkg::RegGreen);
      end else if (hold_count >= 3 * HoldTicks) begin
        load_glyphs(rgbps_pkg::RegBlue);
        hold_count = 0;
      end
    end
    p.red      = lamp_bits[0];
    p.green    = lamp_bits[1];
    p.blue     = lamp_bits[2];
    p.enables  = lit_enables;
    p.segments = lit_segments;
    panel_due_q.push_back(p);
  endtask

  function automatic void check_field(input string name, input logic [6:0] want,
                                      input logic [6:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Write all three levels in back-to-back cycles, then a write to the spare
  // index that the block must ignore. Only called while nothing is in flight.
  task automatic set_levels(input rgbps_pkg::level_t r, input rgbps_pkg::level_t g,
                            input rgbps_pkg::level_t b);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= rgbps_pkg::RegRed;
    cfg_wdata_i <= r;
    @(negedge clk_i);
    cfg_idx_i   <= rgbps_pkg::RegGreen;
    cfg_wdata_i <= g;
    @(negedge clk_i);
    cfg_idx_i   <= rgbps_pkg::RegBlue;
    cfg_wdata_i <= b;
    @(negedge clk_i);
    cfg_idx_i   <= RegSpare;
    cfg_wdata_i <= 7'($urandom_range(127, 0));
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    duty[rgbps_pkg::RegRed]   = r;
    duty[rgbps_pkg::RegGreen] = g;
    duty[rgbps_pkg::RegBlue]  = b;
  endtask

  // Wait until every queued beat went in and every result came out, then
  // let the block settle before returning.
  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid_i || panel_due_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic queue_beat(input logic pwm, input logic scan);
    ticks_t t;
    t.pwm  = pwm;
    t.scan = scan;
    tick_q.push_back(t);
  endtask

  // Input driver. A beat stays on the port until it is accepted; between
  // beats the sender may pause for a random burst.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (send_gap > 0) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (tick_q.size() != 0 && send_idle_pct != 0 &&
                   $urandom_range(99, 0) < send_idle_pct) begin
        send_gap   <= $urandom_range(15, 1) - 1;
        in_valid_i <= 1'b0;
      end else if (tick_q.size() != 0) begin
        next_beat   = tick_q.pop_front();
        in_valid_i  <= 1'b1;
        pwm_tick_i  <= next_beat.pwm;
        scan_tick_i <= next_beat.scan;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output receiver. Random stall bursts, plus one long hold-off while many
  // beats are still pending so that the block fills and stalls its input.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold   <= recv_hold - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet && !long_hold_done && results_seen >= 300 &&
                 tick_q.size() > 100) begin
      long_hold_done <= 1'b1;
      recv_hold      <= LongHold - 1;
      out_stall_i    <= 1'b1;
    end else if (recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct) begin
      recv_hold   <= $urandom_range(15, 1) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: check the result beat first, then predict the input beat taken
  // at the same edge; its result must pass the input and result registers.
  always @(posedge clk_i) begin
    panel_t want;
    if (rst_ni) begin
      in_taken = in_valid_i && !in_stall_o;
      if (in_valid_i && in_stall_o) input_stalled++;
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (panel_due_q.size() == 0) begin
          $error("result beat with no beat outstanding");
          mismatches++;
        end else begin
          want = panel_due_q.pop_front();
          check_field("led_red", 7'(want.red), 7'(led_red_o));
          check_field("led_green", 7'(want.green), 7'(led_green_o));
          check_field("led_blue", 7'(want.blue), 7'(led_blue_o));
          check_field("digit_enables", 7'(want.enables), 7'(digit_enables_o));
          check_field("segments", want.segments, segments_o);
        end
      end
      if (in_taken) step_panel(pwm_tick_i, scan_tick_i);
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $error("no progress: %0d beats still pending, %0d results outstanding",
             tick_q.size(), panel_due_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    int unsigned g;
    int unsigned b;
    for (int i = 0; i < rgbps_pkg::DigitCount; i++) glyph[i] = '0;
    for (int i = 0; i < rgbps_pkg::NumChannels; i++) duty[i] = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the reset levels of zero: every tick combination,
    // idle beats that must repeat the last result, and the first PWM tick
    // that sees a count of zero.
    queue_beat(1'b0, 1'b0);
    queue_beat(1'b1, 1'b0);
    queue_beat(1'b0, 1'b1);
    queue_beat(1'b1, 1'b1);
    queue_beat(1'b0, 1'b0);
    queue_beat(1'b1, 1'b0);
    queue_beat(1'b1, 1'b0);
    queue_beat(1'b0, 1'b1);
    queue_beat(1'b0, 1'b1);
    queue_beat(1'b0, 1'b0);
    queue_beat(1'b1, 1'b1);
    wait_drained();

    // Full scale, the largest level that stays dark, and 127, above the
    // PWM period, which keeps that LED lit for the whole cycle.
    set_levels(7'd99, 7'd1, 7'd127);
    for (int n = 0; n < 12; n++) queue_beat(1'b1, n[0]);
    queue_beat(1'b0, 1'b0);
    queue_beat(1'b0, 1'b1);
    wait_drained();

    // Random phases, each under its own level setting and idling mix. Scan
    // ticks dominate so that the display reloads several times; settings
    // with a level of 100 or more exercise the blank tens digit.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin r = 0;   g = 99;  b = 127; send_idle_pct = 10; recv_idle_pct = 10; end
        1: begin r = 127; g = 100; b = 2;   send_idle_pct = 5;  recv_idle_pct = 20; end
        2: begin r = 50;  g = 127; b = 9;   send_idle_pct = 25; recv_idle_pct = 5;  end
        3: begin
          r = $urandom_range(127, 0);
          g = $urandom_range(127, 0);
          b = $urandom_range(127, 0);
          send_idle_pct = 0;
          recv_idle_pct = 15;
        end
        4: begin r = 99;  g = 0;   b = 127; send_idle_pct = 15; recv_idle_pct = 0;  end
        5: begin
          r = $urandom_range(99, 0);
          g = $urandom_range(99, 0);
          b = $urandom_range(127, 100);
          send_idle_pct = 3;
          recv_idle_pct = 3;
        end
        default: begin
          r = 100; g = 127; b = 1;
          send_idle_pct = 0;
          recv_idle_pct = 0;
          quiet = 1'b1;
        end
      endcase
      set_levels(rgbps_pkg::level_t'(r), rgbps_pkg::level_t'(g), rgbps_pkg::level_t'(b));
      for (int n = 0; n < PhaseBeats; n++) begin
        queue_beat($urandom_range(9, 0) < 7, $urandom_range(19, 0) < 18);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    $display("Covered %0d beats (%0d PWM ticks, %0d scan ticks) over %0d level settings.",
             results_seen, pwm_ticks, scan_ticks, NumPhases + 2);
    $display("Display reloaded %0d times; input held off for %0d cycles.",
             reloads, input_stalled);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
